// ===== rtl/dssr_pkg.sv =====
// Package with item types, request codes, controller states and constants for the servo slew ramp.
`timescale 1ns / 1ps
`default_nettype none

package dssr_pkg;

    // Request codes carried in req_type
    localparam logic [1:0] REQ_SET    = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_STATUS = 2'd2;

    // Compare value is 7200 - (angle*4 + 180) = 7020 - angle*4
    localparam logic [12:0] CMP_BASE = 13'd7020;

    // Smallest divisor the slew step uses
    localparam logic [7:0] DIV_MIN = 8'd2;

    // Restoring divider: one quotient bit per cycle over an 8-bit error
    localparam int DIV_STEPS = 8;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    typedef struct packed {
        logic [1:0] req_type;
        logic       channel;
        logic [7:0] target_angle;
    } in_item_t;

    typedef struct packed {
        logic [12:0] left_compare;
        logic [12:0] right_compare;
        logic [7:0]  left_position;
        logic [7:0]  right_position;
        logic        running;
        logic        finished;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_DIV_APPLY,
        ST_TICK_END,
        ST_EMIT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;   // apply accepted item of any type at accept
        logic div_load;    // load error of div_chan into divider
        logic div_step;    // one quotient bit
        logic div_apply;   // move div_chan's angle by quotient + 1
        logic div_chan;    // 0 left, 1 right
        logic tick_end;    // update run/finish after both channels moved
        logic emit;        // load result register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic run;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/dual_servo_slew_ramp.sv =====
// Top level of the dual servo slew ramp: controller plus datapath.
//
//  Port group        Direction  Handshake           Carries
//  s_*  (items)      in         s_valid / s_ready   dssr_pkg::in_item_t
//  m_*  (results)    out        m_valid / m_ready   dssr_pkg::out_item_t
//  cfg_*             in         cfg_wr_en           slew divisor, 8 bits
//
// Set, status, unused and idle-tick items load the result register 1 cycle after accept.
// A tick while running uses the one restoring divider, which gives a quotient bit a
// cycle: load, steps and apply per channel, left then right, then the flag update and result.
// Synchronous active-low reset clears all angles, goals and flags; divisor is 4.
// One item is in work at a time; a held result stalls the next in the emit step.
`timescale 1ns / 1ps
`default_nettype none

module dual_servo_slew_ramp (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [7:0]          cfg_wr_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire dssr_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output dssr_pkg::out_item_t      m_data
);

    dssr_pkg::dp_cmd_t  cmd;
    dssr_pkg::dp_stat_t stat;

    dssr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .req_type (s_data.req_type),
        .stat     (stat),
        .cmd      (cmd)
    );

    dssr_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (s_data),
        .cmd         (cmd),
        .stat        (stat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

// ===== rtl/dssr_ctrl.sv =====
// Controller state machine sequencing item handling, the shared divider and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module dssr_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         req_type,
    input  wire dssr_pkg::dp_stat_t stat,
    output dssr_pkg::dp_cmd_t       cmd
);

    dssr_pkg::state_t            state_reg, state_next;
    logic                        chan_reg, chan_next;
    logic [dssr_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                        accept;

    assign accept = s_valid && (state_reg == dssr_pkg::ST_IDLE);

    // State and sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dssr_pkg::ST_IDLE;
            chan_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        chan_next  = chan_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            dssr_pkg::ST_IDLE: begin
                if (accept) begin
                    chan_next = 1'b0;
                    if (req_type == dssr_pkg::REQ_TICK && stat.run) begin
                        state_next = dssr_pkg::ST_DIV_LOAD;
                    end else begin
                        state_next = dssr_pkg::ST_EMIT;
                    end
                end
            end
            dssr_pkg::ST_DIV_LOAD: begin
                cnt_next   = '0;
                state_next = dssr_pkg::ST_DIV_STEP;
            end
            dssr_pkg::ST_DIV_STEP: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == dssr_pkg::DIV_LAST) begin
                    state_next = dssr_pkg::ST_DIV_APPLY;
                end
            end
            dssr_pkg::ST_DIV_APPLY: begin
                if (chan_reg) begin
                    state_next = dssr_pkg::ST_TICK_END;
                end else begin
                    chan_next  = 1'b1;
                    state_next = dssr_pkg::ST_DIV_LOAD;
                end
            end
            dssr_pkg::ST_TICK_END: begin
                state_next = dssr_pkg::ST_EMIT;
            end
            dssr_pkg::ST_EMIT: begin
                if (stat.out_free) begin
                    state_next = dssr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dssr_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_ready       = (state_reg == dssr_pkg::ST_IDLE);
        cmd           = '0;
        cmd.div_chan  = chan_reg;
        case (state_reg)
            dssr_pkg::ST_IDLE:      cmd.load_item = accept;
            dssr_pkg::ST_DIV_LOAD:  cmd.div_load  = 1'b1;
            dssr_pkg::ST_DIV_STEP:  cmd.div_step  = 1'b1;
            dssr_pkg::ST_DIV_APPLY: cmd.div_apply = 1'b1;
            dssr_pkg::ST_TICK_END:  cmd.tick_end  = 1'b1;
            dssr_pkg::ST_EMIT:      cmd.emit      = stat.out_free;
            default:                cmd           = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/dssr_dp.sv =====
// Datapath: angle and flag state, divisor register, serial divider and result register.
`timescale 1ns / 1ps
`default_nettype none

module dssr_dp (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [7:0]          cfg_wr_data,
    input  wire dssr_pkg::in_item_t  item,
    input  wire dssr_pkg::dp_cmd_t   cmd,
    output dssr_pkg::dp_stat_t       stat,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output dssr_pkg::out_item_t      m_data
);

    logic [7:0] div_reg;
    logic [7:0] lcur_reg, rcur_reg, lgoal_reg, rgoal_reg;
    logic       run_reg, fin_reg, fin_rep_reg;
    logic [8:0] rem_reg;
    logic [7:0] quo_reg;
    logic       m_valid_reg;
    dssr_pkg::out_item_t m_data_reg;

    logic [7:0] div_eff;
    logic [7:0] lgoal_new, rgoal_new;
    logic       set_moves;
    logic [7:0] sel_cur, sel_goal, sel_err, step;
    logic [8:0] rem_sh;
    logic       sub_ok;
    logic [7:0] moved;
    logic       out_free;

    assign div_eff  = (div_reg < dssr_pkg::DIV_MIN) ? dssr_pkg::DIV_MIN : div_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Goals after a set item
    always_comb begin
        lgoal_new = lgoal_reg;
        rgoal_new = rgoal_reg;
        if (item.channel) begin
            rgoal_new = item.target_angle;
        end else begin
            lgoal_new = item.target_angle;
        end
        set_moves = (lgoal_new != lcur_reg) || (rgoal_new != rcur_reg);
    end

    // Channel under division and its absolute error
    always_comb begin
        sel_cur  = cmd.div_chan ? rcur_reg  : lcur_reg;
        sel_goal = cmd.div_chan ? rgoal_reg : lgoal_reg;
        sel_err  = (sel_cur < sel_goal) ? (sel_goal - sel_cur) : (sel_cur - sel_goal);
        step     = quo_reg + 8'd1;
        if (sel_cur < sel_goal) begin
            moved = sel_cur + step;
        end else if (sel_cur > sel_goal) begin
            moved = sel_cur - step;
        end else begin
            moved = sel_cur;
        end
    end

    // Restoring divide step
    assign rem_sh = {rem_reg[7:0], quo_reg[7]};
    assign sub_ok = (rem_sh >= {1'b0, div_eff});

    // Divisor register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_reg <= 8'd4;
        end else if (cfg_wr_en) begin
            div_reg <= cfg_wr_data;
        end
    end

    // Servo state and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcur_reg    <= '0;
            rcur_reg    <= '0;
            lgoal_reg   <= '0;
            rgoal_reg   <= '0;
            run_reg     <= 1'b0;
            fin_reg     <= 1'b0;
            fin_rep_reg <= 1'b0;
        end else begin
            if (cmd.load_item) begin
                fin_rep_reg <= fin_reg;
                case (item.req_type)
                    dssr_pkg::REQ_SET: begin
                        lgoal_reg <= lgoal_new;
                        rgoal_reg <= rgoal_new;
                        if (set_moves) begin
                            run_reg <= 1'b1;
                        end else begin
                            fin_reg     <= 1'b1;
                            fin_rep_reg <= 1'b1;
                        end
                    end
                    dssr_pkg::REQ_STATUS: begin
                        fin_reg <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.div_apply) begin
                if (cmd.div_chan) begin
                    rcur_reg <= moved;
                end else begin
                    lcur_reg <= moved;
                end
            end
            if (cmd.tick_end) begin
                if (lcur_reg == lgoal_reg && rcur_reg == rgoal_reg) begin
                    run_reg     <= 1'b0;
                    fin_reg     <= 1'b1;
                    fin_rep_reg <= 1'b1;
                end else begin
                    fin_rep_reg <= fin_reg;
                end
            end
        end
    end

    // Serial divider registers
    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            rem_reg <= '0;
            quo_reg <= sel_err;
        end else if (cmd.div_step) begin
            rem_reg <= sub_ok ? (rem_sh - {1'b0, div_eff}) : rem_sh;
            quo_reg <= {quo_reg[6:0], sub_ok};
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg.left_compare   <= dssr_pkg::CMP_BASE - {3'b000, lcur_reg, 2'b00};
            m_data_reg.right_compare  <= dssr_pkg::CMP_BASE - {3'b000, rcur_reg, 2'b00};
            m_data_reg.left_position  <= lcur_reg;
            m_data_reg.right_position <= rcur_reg;
            m_data_reg.running        <= run_reg;
            m_data_reg.finished       <= fin_rep_reg;
        end
    end

    assign stat.run      = run_reg;
    assign stat.out_free = out_free;
    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;

endmodule

`default_nettype wire

// ===== rtl/dssr_chk.sv =====
// Port-level checker for the dual servo slew ramp, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dssr_chk (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire dssr_pkg::in_item_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire dssr_pkg::out_item_t m_data
);

    // No result right after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A held result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // Compare values follow the reported positions
    a_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.left_compare ==
                     (dssr_pkg::CMP_BASE - {3'b000, m_data.left_position, 2'b00}))
                 && (m_data.right_compare ==
                     (dssr_pkg::CMP_BASE - {3'b000, m_data.right_position, 2'b00})))
        else $error("compare value does not match position");

    // One item at a time: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted back to back");

    // A waiting input item holds still until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("waiting input item changed");

endmodule

bind dual_servo_slew_ramp dssr_chk u_dssr_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// ===== test/tb_dual_servo_slew_ramp.sv =====
// Testbench for the dual servo slew ramp: directed and random requests, checked against a predictor.
`timescale 1ns / 1ps

module tb_dual_servo_slew_ramp;

    // req_type 3 has no meaning in the block
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES = 30;
    localparam int unsigned SEGMENT_ITEMS = 333;

    // Predicts every result from the accepted items and checks the block's results
    class servo_ramp_scoreboard;
        logic [7:0] divisor;
        logic [7:0] left_cur;
        logic [7:0] right_cur;
        logic [7:0] left_goal;
        logic [7:0] right_goal;
        bit         run_f;
        bit         fin_f;
        dssr_pkg::out_item_t awaited[$];
        int         errors;

        function new();
            divisor    = 8'd4;
            left_cur   = '0;
            right_cur  = '0;
            left_goal  = '0;
            right_goal = '0;
            run_f      = 1'b0;
            fin_f      = 1'b0;
            errors     = 0;
        endfunction

        function void set_divisor(logic [7:0] value);
            divisor = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function logic [12:0] angle_to_compare(logic [7:0] angle);
            int unsigned a;
            a = angle;
            return 13'(7200 - (a * 4 + 180));
        endfunction

        // One step toward the goal: error / divisor + 1, never past it
        function logic [7:0] slew_toward(logic [7:0] cur, logic [7:0] goal, int unsigned div);
            int unsigned c;
            int unsigned g;
            c = cur;
            g = goal;
            if (c < g) begin
                c = c + (g - c) / div + 1;
            end else if (c > g) begin
                c = c - ((c - g) / div + 1);
            end
            return 8'(c);
        endfunction

        function void note_item(dssr_pkg::in_item_t it);
            dssr_pkg::out_item_t res;
            int unsigned div;
            bit          fin_seen;
            case (it.req_type)
                dssr_pkg::REQ_SET: begin
                    if (it.channel == 1'b0) left_goal = it.target_angle;
                    else right_goal = it.target_angle;
                    if (left_goal != left_cur || right_goal != right_cur) run_f = 1'b1;
                    else fin_f = 1'b1;
                end
                dssr_pkg::REQ_TICK: begin
                    if (run_f) begin
                        div = (divisor < 8'd2) ? 2 : int'(divisor);
                        left_cur  = slew_toward(left_cur, left_goal, div);
                        right_cur = slew_toward(right_cur, right_goal, div);
                        if (left_cur == left_goal && right_cur == right_goal) begin
                            run_f = 1'b0;
                            fin_f = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            // a status read reports the flag as it was, then clears it
            fin_seen = fin_f;
            if (it.req_type == dssr_pkg::REQ_STATUS) fin_f = 1'b0;
            res.left_compare   = angle_to_compare(left_cur);
            res.right_compare  = angle_to_compare(right_cur);
            res.left_position  = left_cur;
            res.right_position = right_cur;
            res.running        = run_f;
            res.finished       = fin_seen;
            awaited.push_back(res);
        endfunction

        function void compare_field(string name, logic [12:0] exp_v, logic [12:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(dssr_pkg::out_item_t got);
            dssr_pkg::out_item_t want;
            if (awaited.size() == 0) begin
                $error("result with no item outstanding: %h", got);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare_field("left_compare", want.left_compare, got.left_compare);
            compare_field("right_compare", want.right_compare, got.right_compare);
            compare_field("left_position", 13'(want.left_position), 13'(got.left_position));
            compare_field("right_position", 13'(want.right_position), 13'(got.right_position));
            compare_field("running", 13'(want.running), 13'(got.running));
            compare_field("finished", 13'(want.finished), 13'(got.finished));
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = '0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    dssr_pkg::in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    dssr_pkg::out_item_t m_data;

    servo_ramp_scoreboard sb = new();
    int unsigned send_idle_pct = 33;
    int unsigned recv_idle_pct = 52;
    int unsigned sent_count = 0;

    dual_servo_slew_ramp uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // 2 ns clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic dssr_pkg::in_item_t build_request(logic [1:0] req, logic chan,
                                                         logic [7:0] angle);
        dssr_pkg::in_item_t it;
        it.req_type     = req;
        it.channel      = chan;
        it.target_angle = angle;
        return it;
    endfunction

    // Goal angle: mostly random, sometimes an extreme or the channel's present angle
    function automatic logic [7:0] pick_angle(logic chan);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0: return 8'd0;
            1: return 8'd255;
            2: return chan ? sb.right_cur : sb.left_cur;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Enter and leave at a falling edge; valid stays up after the accept
    task automatic send_item(input dssr_pkg::in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
        sent_count++;
        @(negedge aclk);
    endtask

    // Hold off the sender until every outstanding result is in
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    task automatic write_divisor(input logic [7:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_divisor(value);
        @(negedge aclk);
    endtask

    task automatic tick_until_settled(input int unsigned cap);
        int unsigned n;
        n = 0;
        while (sb.run_f && n < cap) begin
            send_item(build_request(dssr_pkg::REQ_TICK, 1'($urandom_range(0, 1)),
                                    8'($urandom_range(0, 255))));
            n++;
        end
    endtask

    // Mostly full moves (goals, ticks, status); the rest noise and hold-offs
    task automatic random_segment(input logic [7:0] div_value, input int unsigned n_items);
        int unsigned goal_count;
        int unsigned roll;
        logic        chan;
        write_divisor(div_value);
        goal_count = sent_count + n_items;
        while (sent_count < goal_count) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                chan = 1'($urandom_range(0, 1));
                send_item(build_request(dssr_pkg::REQ_SET, chan, pick_angle(chan)));
                if ($urandom_range(0, 1)) begin
                    send_item(build_request(dssr_pkg::REQ_SET, ~chan, pick_angle(~chan)));
                end
                // sometimes cut the move short so a new goal lands mid-ramp
                tick_until_settled(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 300);
                send_item(build_request(dssr_pkg::REQ_STATUS, 1'($urandom_range(0, 1)),
                                        8'($urandom_range(0, 255))));
            end else if (roll < 98) begin
                send_item(build_request(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                        8'($urandom_range(0, 255))));
            end else begin
                drain();
            end
        end
    endtask

    // Result side: ready changes at the falling edge, results checked at the rising edge
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_result(m_data);
            @(negedge aclk);
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run after too many cycles with no item moving
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("dual_servo_slew_ramp: mismatch");
        $finish;
    end

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed, reset divisor: idle tick, status, unused code, start a move
        send_item(build_request(dssr_pkg::REQ_TICK, 1'b1, 8'd200));
        send_item(build_request(dssr_pkg::REQ_STATUS, 1'b0, 8'd0));
        send_item(build_request(REQ_UNUSED, 1'b1, 8'hFF));
        send_item(build_request(dssr_pkg::REQ_SET, 1'b1, 8'd255));
        send_item(build_request(dssr_pkg::REQ_SET, 1'b0, 8'd0));
        send_item(build_request(dssr_pkg::REQ_STATUS, 1'b1, 8'hAA));
        tick_until_settled(3);

        // Divisor below the minimum; finish the move and read the flag twice
        write_divisor(8'd0);
        tick_until_settled(20);
        send_item(build_request(dssr_pkg::REQ_TICK, 1'b0, 8'h55));
        send_item(build_request(dssr_pkg::REQ_STATUS, 1'b0, 8'd0));
        send_item(build_request(dssr_pkg::REQ_STATUS, 1'b1, 8'd0));

        // Goal set back onto the present angle while running
        send_item(build_request(dssr_pkg::REQ_SET, 1'b0, 8'd10));
        send_item(build_request(dssr_pkg::REQ_TICK, 1'b0, 8'd0));
        send_item(build_request(dssr_pkg::REQ_SET, 1'b0, sb.left_cur));
        send_item(build_request(dssr_pkg::REQ_TICK, 1'b0, 8'd0));
        // Goal equal to the present angle while idle
        send_item(build_request(dssr_pkg::REQ_SET, 1'b1, 8'd255));

        // Sender 33, receiver 52 percent idle
        random_segment(8'd2, SEGMENT_ITEMS);
        random_segment(8'd255, SEGMENT_ITEMS);

        // Roles swapped
        send_idle_pct = 52;
        recv_idle_pct = 33;
        random_segment(8'd1, SEGMENT_ITEMS);
        random_segment(8'($urandom_range(3, 254)), SEGMENT_ITEMS);

        // No idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_segment(8'($urandom_range(0, 255)), SEGMENT_ITEMS);
        random_segment(8'd4, SEGMENT_ITEMS);

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("dual_servo_slew_ramp: match");
        end else begin
            $display("dual_servo_slew_ramp: mismatch");
        end
        $finish;
    end

endmodule
